// ===== rtl/tbrl_pkg.sv =====
// shared widths, codes and interface structs of the token bucket rate limiter
`default_nettype none

package tbrl_pkg;

  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned TPM_W      = 24;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned BKT_W      = 2;
  localparam int unsigned NUM_LIMITS = 4;
  // capacity is rpm times ticks per minute, below 2**40
  localparam int unsigned TOK_W      = LIMIT_W + TPM_W;
  localparam int unsigned PROD_W     = TICK_W + LIMIT_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_W      = TPM_W;

  localparam logic [TPM_W-1:0] TPM_RESET = 24'd6000000;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT0 = 3'd0,
    REG_LIMIT1 = 3'd1,
    REG_LIMIT2 = 3'd2,
    REG_LIMIT3 = 3'd3,
    REG_TPM    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_PROD,
    ST_NEED,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] rpm;
    logic [TPM_W-1:0]   tpm;
    logic               primed;
    logic [TOK_W-1:0]   tokens;
    logic [TICK_W-1:0]  last;
  } bkt_rd_t;

  typedef struct packed {
    logic              en;
    logic [BKT_W-1:0]  bucket;
    logic [TOK_W-1:0]  tokens;
    logic [TICK_W-1:0] now;
  } bkt_wr_t;

endpackage

`default_nettype wire

// ===== rtl/tbrl_serial_mult.sv =====
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module tbrl_serial_mult #(
  parameter int unsigned MCAND_W = 32,
  parameter int unsigned MPLR_W  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [MCAND_W-1:0]         mcand_i,
  input  logic [MPLR_W-1:0]          mplr_i,
  output logic                       done_o,
  output logic [MCAND_W+MPLR_W-1:0]  prod_o
);

  localparam int unsigned PW = MCAND_W + MPLR_W;
  localparam int unsigned CW = $clog2(MPLR_W + 1);

  logic [PW-1:0]      p_q;
  logic [MCAND_W-1:0] mcand_q;
  logic [CW-1:0]      cnt_q;
  logic               done_q;

  logic [MCAND_W-1:0] addend;
  logic [MCAND_W:0]   upper_sum;
  logic [PW-1:0]      p_step;

  // multiplier bits leave at the bottom, partial sum enters at the top
  always_comb begin
    addend    = p_q[0] ? mcand_q : '0;
    upper_sum = {1'b0, p_q[PW-1:MPLR_W]} + {1'b0, addend};
    p_step    = {upper_sum, p_q[MPLR_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(MPLR_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q     <= {{MCAND_W{1'b0}}, mplr_i};
      mcand_q <= mcand_i;
    end else if (cnt_q != '0) begin
      p_q <= p_step;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/tbrl_serial_div.sv =====
// restoring divider for the fill fraction, one quotient bit per cycle
`default_nettype none

module tbrl_serial_div #(
  parameter int unsigned NUM_W  = 40,
  parameter int unsigned FRAC_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [NUM_W-1:0]  den_i,
  output logic              done_o,
  output logic [FRAC_W:0]   quo_o
);

  localparam int unsigned CW = $clog2(FRAC_W + 1);

  logic [NUM_W-1:0] rem_q;
  logic [NUM_W-1:0] den_q;
  logic [FRAC_W:0]  quo_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;

  logic             full;
  logic [NUM_W:0]   rem_sh;
  logic [NUM_W:0]   rem_diff;
  logic             ge;

  always_comb begin
    full     = (num_i >= den_i);
    rem_sh   = {rem_q, 1'b0};
    rem_diff = rem_sh - {1'b0, den_q};
    ge       = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      // a full bucket needs no iterations
      cnt_q  <= full ? '0 : CW'(FRAC_W);
      done_q <= full;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= full ? ((FRAC_W + 1)'(1) << FRAC_W) : '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
      quo_q <= {quo_q[FRAC_W-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/tbrl_bucket_table.sv =====
// configuration registers and per-bucket token state
`default_nettype none

module tbrl_bucket_table import tbrl_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [BKT_W-1:0]     rd_bucket_i,
  output bkt_rd_t              rd_o,
  input  bkt_wr_t              wr_i
);

  localparam int unsigned NB = (NUM_BUCKETS < NUM_LIMITS) ? NUM_BUCKETS : NUM_LIMITS;

  logic [LIMIT_W-1:0] limit_q [NUM_LIMITS];
  logic [TPM_W-1:0]   tpm_q;
  logic [NB-1:0]      primed_q;
  logic [TOK_W-1:0]   tokens_q [NB];
  logic [TICK_W-1:0]  last_q [NB];

  cfg_reg_e cfg_sel;
  assign cfg_sel = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIMITS; i++) begin
        limit_q[i] <= '0;
      end
      tpm_q <= TPM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_sel) inside
        REG_LIMIT0, REG_LIMIT1, REG_LIMIT2, REG_LIMIT3: begin
          limit_q[cfg_index_i[BKT_W-1:0]] <= cfg_data_i[LIMIT_W-1:0];
        end
        REG_TPM: begin
          // zero ticks per minute behaves as one
          tpm_q <= (cfg_data_i == '0) ? TPM_W'(1) : cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // a bucket reads as full until its first access after a limit or scale write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else begin
      for (int j = 0; j < NB; j++) begin
        if (cfg_we_i && (cfg_index_i == CFG_IDX_W'(j) || cfg_sel == REG_TPM)) begin
          primed_q[j] <= 1'b0;
        end else if (wr_i.en && wr_i.bucket == BKT_W'(j)) begin
          primed_q[j] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NB; j++) begin
      if (wr_i.en && wr_i.bucket == BKT_W'(j)) begin
        tokens_q[j] <= wr_i.tokens;
        last_q[j]   <= wr_i.now;
      end
    end
  end

  always_comb begin
    rd_o.tpm    = tpm_q;
    rd_o.rpm    = ({1'b0, rd_bucket_i} < (BKT_W + 1)'(NB)) ? limit_q[rd_bucket_i] : '0;
    rd_o.primed = 1'b0;
    rd_o.tokens = '0;
    rd_o.last   = '0;
    for (int j = 0; j < NB; j++) begin
      if (rd_bucket_i == BKT_W'(j)) begin
        rd_o.primed = primed_q[j];
        rd_o.tokens = tokens_q[j];
        rd_o.last   = last_q[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/token_bucket_rate_limiter.sv =====
// token bucket rate limiter top level: sequencer, shared serial units, result register
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o   kind, bucket, count, now_ticks
//   out      out        out_valid_o / out_ready_i granted, fill_fraction, unlimited
//
// one request at a time; an unlimited bucket goes from accept to the result state,
// then to the output register; a limited bucket runs the shift-add multiplier for
// capacity, then refill if primed, then tokens needed for a request; a query instead
// runs the divider, which skips its iterations when the bucket is full
// reset clears control state and all primed flags, tokens need no clearing pass
// a waiting result sits in the output register while the next request is accepted
`default_nettype none

module token_bucket_rate_limiter import tbrl_pkg::*; #(
  parameter int unsigned NUM_BUCKETS   = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  input  logic [BKT_W-1:0]     in_bucket_i,
  input  logic [COUNT_W-1:0]   in_count_i,
  input  logic [TICK_W-1:0]    in_now_ticks_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_granted_o,
  output logic [FRACTION_BITS:0] out_fill_fraction_o,
  output logic                 out_unlimited_o
);

  localparam int unsigned FILL_W = FRACTION_BITS + 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(1) << FRACTION_BITS;

  state_e state_q, state_d;

  bkt_rd_t rd;
  bkt_wr_t commit;

  logic               in_acc;
  logic               limited;

  logic               kind_q;
  logic [BKT_W-1:0]   bkt_q;
  logic [COUNT_W-1:0] count_q;
  logic [TICK_W-1:0]  now_q;
  logic [LIMIT_W-1:0] rpm_q;
  logic [TICK_W-1:0]  elapsed_q;
  logic               hit_primed_q;

  logic [TOK_W-1:0]   tok_q, tok_d;
  logic [TOK_W-1:0]   cap_q, cap_d;
  logic               gr_q, gr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               unl_q, unl_d;

  logic               out_valid_q;
  logic               out_load;
  logic               granted_q;
  logic [FILL_W-1:0]  fill_out_q;
  logic               unl_out_q;

  logic               mul_start;
  logic [TICK_W-1:0]  mul_mcand;
  logic [LIMIT_W-1:0] mul_mplr;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;

  logic               div_start;
  logic [TOK_W-1:0]   div_num;
  logic [TOK_W-1:0]   div_den;
  logic               div_done;
  logic [FILL_W-1:0]  div_quo;

  logic [PROD_W:0]    refill_sum;
  logic [TOK_W-1:0]   refill;
  logic [TOK_W:0]     need_diff;

  tbrl_bucket_table #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rd_bucket_i(in_bucket_i),
    .rd_o       (rd),
    .wr_i       (commit)
  );

  tbrl_serial_mult #(
    .MCAND_W(TICK_W),
    .MPLR_W (LIMIT_W)
  ) u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .mcand_i(mul_mcand),
    .mplr_i (mul_mplr),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  tbrl_serial_div #(
    .NUM_W (TOK_W),
    .FRAC_W(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign limited    = (rd.rpm != '0);
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // refill saturates at capacity, consume checks with one borrow
  always_comb begin
    refill_sum = (PROD_W + 1)'(tok_q) + (PROD_W + 1)'(mul_prod);
    refill     = (refill_sum > (PROD_W + 1)'(cap_q)) ? cap_q : refill_sum[TOK_W-1:0];
    need_diff  = {1'b0, tok_q} - {1'b0, mul_prod[TOK_W-1:0]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = limited ? ST_CAP : ST_RESULT;
        end
      end
      ST_CAP: begin
        if (mul_done) begin
          if (hit_primed_q) begin
            state_d = ST_PROD;
          end else begin
            state_d = (kind_q == KIND_QUERY) ? ST_DIV : ST_NEED;
          end
        end
      end
      ST_PROD: begin
        if (mul_done) begin
          state_d = (kind_q == KIND_QUERY) ? ST_DIV : ST_NEED;
        end
      end
      ST_NEED: begin
        if (mul_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start     = 1'b0;
    mul_mcand     = TICK_W'(rd.tpm);
    mul_mplr      = rd.rpm;
    div_start     = 1'b0;
    div_num       = refill;
    div_den       = cap_q;
    commit.en     = 1'b0;
    commit.bucket = bkt_q;
    commit.now    = now_q;
    commit.tokens = tok_q;
    tok_d         = tok_q;
    cap_d         = cap_q;
    gr_d          = gr_q;
    fill_d        = fill_q;
    unl_d         = unl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mul_start = limited;
          tok_d     = rd.tokens;
          gr_d      = !limited;
          unl_d     = !limited;
          fill_d    = (!limited && in_kind_i == KIND_QUERY) ? FILL_FULL : '0;
        end
      end
      ST_CAP: begin
        if (mul_done) begin
          cap_d = mul_prod[TOK_W-1:0];
          if (hit_primed_q) begin
            mul_start = 1'b1;
            mul_mcand = elapsed_q;
            mul_mplr  = rpm_q;
          end else begin
            // first access starts full
            tok_d = mul_prod[TOK_W-1:0];
            if (kind_q == KIND_QUERY) begin
              div_start = 1'b1;
              div_num   = mul_prod[TOK_W-1:0];
              div_den   = mul_prod[TOK_W-1:0];
            end else begin
              mul_start = 1'b1;
              mul_mplr  = LIMIT_W'(count_q);
            end
          end
        end
      end
      ST_PROD: begin
        if (mul_done) begin
          tok_d = refill;
          if (kind_q == KIND_QUERY) begin
            div_start = 1'b1;
          end else begin
            mul_start = 1'b1;
            mul_mplr  = LIMIT_W'(count_q);
          end
        end
      end
      ST_NEED: begin
        if (mul_done) begin
          if (!need_diff[TOK_W]) begin
            tok_d = need_diff[TOK_W-1:0];
            gr_d  = 1'b1;
          end
          commit.en     = 1'b1;
          commit.tokens = tok_d;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          fill_d    = div_quo;
          commit.en = 1'b1;
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q       <= in_kind_i;
      bkt_q        <= in_bucket_i;
      count_q      <= in_count_i;
      now_q        <= in_now_ticks_i;
      rpm_q        <= rd.rpm;
      elapsed_q    <= in_now_ticks_i - rd.last;
      hit_primed_q <= rd.primed;
    end
    tok_q  <= tok_d;
    cap_q  <= cap_d;
    gr_q   <= gr_d;
    fill_q <= fill_d;
    unl_q  <= unl_d;
    if (out_load) begin
      granted_q  <= gr_q;
      fill_out_q <= fill_q;
      unl_out_q  <= unl_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_granted_o       = granted_q;
  assign out_fill_fraction_o = fill_out_q;
  assign out_unlimited_o     = unl_out_q;

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_CAP || state_q == ST_PROD || state_q == ST_NEED))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_tokens_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEED || state_q == ST_DIV) |-> (tok_q <= cap_q))
    else $error("bucket holds more tokens than its capacity");

  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cap_q != '0))
    else $error("divide started with zero capacity");

  a_unlimited_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_unlimited_o) |-> out_granted_o)
    else $error("unlimited bucket result not granted");

endmodule

`default_nettype wire
